// ----- rtl/fam_pkg.sv -----
// ----------------------------------------------------------------------------
// fam_pkg: shared types, constants and AES helpers for the frame MAC block
// Holds the AES S-box, key schedule step, round function and queue entry type.
// ----------------------------------------------------------------------------
package fam_pkg;

  localparam int HEAD_BYTES_DEF = 8;
  localparam int KEY_W          = 64;
  localparam int SEQ_W          = 16;
  localparam int MAC_W          = 48;
  localparam int CHK_W          = 16;
  localparam logic [7:0] PAD_BYTE = 8'h55;
  localparam logic [7:0] CHK_XOR2 = 8'h5b;
  localparam int NUM_ROUNDS     = 10;

  // Register indexes of the configuration port.
  localparam logic CFG_KEY_HI = 1'b0;
  localparam logic CFG_KEY_LO = 1'b1;

  // One finished frame waiting for encryption.
  typedef struct packed {
    logic [127:0] block;
    logic [127:0] key;
    logic [CHK_W-1:0] check;
  } job_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] r;
    case (a)
      8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
      8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
      8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
      8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
      8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
      8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
      8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
      8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
      8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
      8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
      8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
      8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
      8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
      8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
      8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
      8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
      8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
      8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
      8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
      8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
      8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
      8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
      8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
      8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
      8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
      8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
      8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
      8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
      8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
      8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
      8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
      8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
      8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
      8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
      8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
      8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
      8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
      8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
      8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
      8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
      8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
      8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
      8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
      8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
      8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
      8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
      8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
      8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
      8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
      8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
      8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
      8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
      8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
      8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
      8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
      8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
      8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
      8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
      8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
      8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
      8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
      8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
      8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
      8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  // Byte i of a 128-bit word sits in bits 127-8i .. 120-8i.
  function automatic logic [127:0] next_round_key(input logic [127:0] k,
                                                  input logic [7:0] rcon);
    logic [31:0] w0, w1, w2, w3, t;
    begin
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t  = {sbox(w3[23:16]) ^ rcon, sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
    end
  endfunction

  // SubBytes, ShiftRows and, unless final, MixColumns.
  function automatic logic [127:0] aes_round(input logic [127:0] s, input logic last);
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, all;
    logic [127:0] r;
    begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++)
          t[c*4+i] = sbox(s[127 - 8*(((c+i)%4)*4+i) -: 8]);
      if (!last) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[c*4]; a1 = t[c*4+1]; a2 = t[c*4+2]; a3 = t[c*4+3];
          all = a0 ^ a1 ^ a2 ^ a3;
          t[c*4]   = a0 ^ all ^ xtime(a0 ^ a1);
          t[c*4+1] = a1 ^ all ^ xtime(a1 ^ a2);
          t[c*4+2] = a2 ^ all ^ xtime(a2 ^ a3);
          t[c*4+3] = a3 ^ all ^ xtime(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) r[127 - 8*i -: 8] = t[i];
      return r;
    end
  endfunction

endpackage

// ----- rtl/fam_front.sv -----
// ----------------------------------------------------------------------------
// fam_front: byte intake
// Runs the checksum, keeps the frame head and builds the block on the last byte.
// ----------------------------------------------------------------------------
module fam_front #(
  parameter int HEAD_BYTES = fam_pkg::HEAD_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic [15:0]          seq_number,
  input  logic                 last_byte,
  input  logic [127:0]         key,
  output logic                 job_valid,
  input  logic                 job_ready,
  output fam_pkg::job_t        job
);
  import fam_pkg::*;

  localparam int CNT_W = $clog2(HEAD_BYTES + 1);

  logic [7:0] check_first, check_second, cf_next, cs_next, mix, nf;
  logic [8*HEAD_BYTES-1:0] iv_head, head_next;
  logic [CNT_W-1:0] byte_count;
  logic take;

  // The output stage of the queue can hold one job; a byte may enter
  // whenever that stage is free or drains this cycle.
  assign in_ready = !job_valid || job_ready;
  assign take     = in_valid && in_ready;

  always_comb begin
    mix = data_byte ^ check_second;
    nf  = {check_first[6:0], mix[7]};
    if (check_first[7]) begin
      cf_next = nf ^ PAD_BYTE;
      cs_next = {mix[6:0], 1'b0} ^ CHK_XOR2;
    end else begin
      cf_next = nf;
      cs_next = {mix[6:0], 1'b0};
    end
    head_next = iv_head;
    if (byte_count < CNT_W'(HEAD_BYTES))
      head_next[8*HEAD_BYTES-1 - 8*byte_count -: 8] = data_byte;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      check_first  <= '0;
      check_second <= '0;
      iv_head      <= {HEAD_BYTES{PAD_BYTE}};
      byte_count   <= '0;
      job_valid    <= 1'b0;
    end else begin
      if (take && last_byte) job_valid <= 1'b1;
      else if (job_ready) job_valid <= 1'b0;
      if (take) begin
        if (last_byte) begin
          check_first  <= '0;
          check_second <= '0;
          iv_head      <= {HEAD_BYTES{PAD_BYTE}};
          byte_count   <= '0;
        end else begin
          check_first  <= cf_next;
          check_second <= cs_next;
          iv_head      <= head_next;
          if (byte_count < CNT_W'(HEAD_BYTES)) byte_count <= byte_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && last_byte) begin
      job.block <= {head_next[8*HEAD_BYTES-1 -: 64], cf_next, cs_next, seq_number,
                    {4{PAD_BYTE}}};
      job.key   <= key;
      job.check <= {cf_next, cs_next};
    end
  end
endmodule

// ----- rtl/fam_aes.sv -----
// ----------------------------------------------------------------------------
// fam_aes: AES-128 pipeline
// Ten registered rounds with the key schedule carried alongside each stage.
// ----------------------------------------------------------------------------
module fam_aes (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   job_valid,
  output logic                   job_ready,
  input  fam_pkg::job_t          job,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [fam_pkg::MAC_W-1:0] mac,
  output logic [fam_pkg::CHK_W-1:0] iv_check
);
  import fam_pkg::*;

  localparam int NS = NUM_ROUNDS + 1;
  localparam logic [7:0] RCON [NUM_ROUNDS] = '{8'h01, 8'h02, 8'h04, 8'h08, 8'h10,
                                               8'h20, 8'h40, 8'h80, 8'h1b, 8'h36};

  logic [NS-1:0]  vld;
  logic [127:0]   st  [NS];
  logic [127:0]   rk  [NS];
  logic [CHK_W-1:0] chk [NS];
  logic [127:0]   rk_next [NS];
  logic           adv;

  // The whole pipe moves together; the last stage doubles as the output register.
  assign adv       = !vld[NS-1] || out_ready;
  assign job_ready = adv;
  assign out_valid = vld[NS-1];
  assign mac       = st[NS-1][127 -: MAC_W];
  assign iv_check  = chk[NS-1];

  always_comb begin
    for (int i = 0; i < NS; i++) rk_next[i] = rk[i];
    for (int i = 0; i < NS-1; i++) rk_next[i] = next_round_key(rk[i], RCON[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NS-2:0], job_valid};
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      st[0]  <= job.block ^ job.key;
      rk[0]  <= job.key;
      chk[0] <= job.check;
      for (int i = 1; i < NS; i++) begin
        st[i]  <= aes_round(st[i-1], i == NUM_ROUNDS) ^ rk_next[i-1];
        rk[i]  <= rk_next[i-1];
        chk[i] <= chk[i-1];
      end
    end
  end
endmodule

// ----- rtl/frame_auth_mac.sv -----
// ----------------------------------------------------------------------------
// frame_auth_mac: per-frame truncated AES-128 authentication code
// Top level: configuration registers, byte intake and AES pipeline.
// ----------------------------------------------------------------------------
// Usage: payload bytes enter on the s_axis channel, one per beat, with
// s_axis_tlast marking the last byte of a frame; the sequence number rides
// in tdata and is sampled only on that last beat. Each frame produces one
// beat on m_axis carrying the 48-bit MAC and the 16-bit checksum.
// A byte is taken every cycle while s_axis_tready is high. On the last
// byte of a frame the block is registered at the accepting edge and then
// passes eleven AES pipeline stages (initial key add and ten rounds, each
// with its own key step). Up to twelve frames may be in flight, so frames
// may follow each other back to back. When m_axis stalls the whole pipe
// holds and s_axis_tready drops once the job stage is also full. Reset
// clears the pipeline and the frame state and sets both key registers to
// zero. Keys are written through cfg_we/cfg_addr/cfg_wdata; a key write is
// seen by the next frame whose last byte is accepted after it.
// ----------------------------------------------------------------------------
module frame_auth_mac #(
  parameter int HEAD_BYTES = fam_pkg::HEAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [63:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // data_byte[7:0], seq_number[23:8]
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata   // mac[47:0], iv_check[63:48]
);
  import fam_pkg::*;

  logic [KEY_W-1:0] auth_key_hi, auth_key_lo;
  logic job_valid, job_ready;
  job_t job;
  logic [MAC_W-1:0] mac;
  logic [CHK_W-1:0] iv_check;

  always_ff @(posedge clk) begin
    if (rst) begin
      auth_key_hi <= '0;
      auth_key_lo <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_KEY_HI: auth_key_hi <= cfg_wdata;
        CFG_KEY_LO: auth_key_lo <= cfg_wdata;
        default: ;
      endcase
    end
  end

  fam_front #(.HEAD_BYTES(HEAD_BYTES)) u_front (
    .clk, .rst,
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .data_byte (s_axis_tdata[7:0]),
    .seq_number(s_axis_tdata[23:8]),
    .last_byte (s_axis_tlast),
    .key       ({auth_key_hi, auth_key_lo}),
    .job_valid, .job_ready, .job
  );

  fam_aes u_aes (
    .clk, .rst, .job_valid, .job_ready, .job,
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .mac, .iv_check
  );

  assign m_axis_tdata = {iv_check, mac};

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");
  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !job_valid |-> s_axis_tready)
    else $error("intake stalled with empty job stage");
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid && $stable(job))
    else $error("queued job lost");
endmodule

// ----- tb/tb_frame_auth_mac.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_frame_auth_mac: self-checking bench for the frame MAC block
// Drives payload bytes as frames, predicts each frame's truncated AES MAC
// and checksum, and compares every output beat against the queued result.
// ----------------------------------------------------------------------------
module tb_frame_auth_mac;
  import fam_pkg::*;

  typedef struct packed {
    logic [47:0] mac;
    logic [15:0] chk;
  } mac_res_t;

  typedef struct {
    logic [7:0]  data;
    logic [15:0] seq;
    logic        last;
    logic        typed;
    mac_res_t    res;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_addr = 1'b0;
  logic [63:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  frame_auth_mac dut (.*);

  always #10 clk = ~clk;

  // Predictor state.
  logic [63:0] key_hi, key_lo;
  logic [7:0]  chk_a, chk_b;
  logic [63:0] head;
  int          head_cnt;

  mac_res_t    mac_q [$];
  int          n_err = 0, n_beats = 0, n_frames = 0, n_bytes = 0;
  int          src_idle = 0, snk_idle = 0;
  bit          snk_hold = 0;

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [7:0] sb(input logic [7:0] a);
    logic [7:0] x, inv, r;
    // Inverse in GF(2^8) by exponentiation to 254, then the affine step.
    logic [7:0] b;
    int e;
    inv = 8'h01; b = a; e = 254;
    while (e > 0) begin
      if (e & 1) inv = gmul(inv, b);
      b = gmul(b, b);
      e >>= 1;
    end
    x = inv;
    r = x ^ {x[6:0], x[7]} ^ {x[5:0], x[7:6]} ^ {x[4:0], x[7:5]} ^ {x[3:0], x[7:4]} ^ 8'h63;
    return r;
  endfunction

  function automatic logic [127:0] aes128(input logic [127:0] key, input logic [127:0] pt);
    logic [7:0] rk [176];
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] w [4];
    logic [7:0] tmp, all, rc;
    logic [127:0] o;
    rc = 8'h01;
    for (int i = 0; i < 16; i++) rk[i] = key[127-8*i -: 8];
    for (int i = 16; i < 176; i += 4) begin
      for (int j = 0; j < 4; j++) w[j] = rk[i-4+j];
      if (i % 16 == 0) begin
        tmp = w[0];
        w[0] = sb(w[1]) ^ rc; w[1] = sb(w[2]); w[2] = sb(w[3]); w[3] = sb(tmp);
        rc = gmul(rc, 8'h02);
      end
      for (int j = 0; j < 4; j++) rk[i+j] = rk[i-16+j] ^ w[j];
    end
    for (int i = 0; i < 16; i++) s[i] = pt[127-8*i -: 8] ^ rk[i];
    for (int r = 1; r <= 10; r++) begin
      for (int c = 0; c < 4; c++)
        for (int i = 0; i < 4; i++) t[c*4+i] = sb(s[((c+i)%4)*4+i]);
      if (r != 10) begin
        for (int c = 0; c < 4; c++) begin
          for (int j = 0; j < 4; j++) w[j] = t[c*4+j];
          all = w[0] ^ w[1] ^ w[2] ^ w[3];
          for (int j = 0; j < 4; j++)
            t[c*4+j] = w[j] ^ all ^ gmul(w[j] ^ w[(j+1)%4], 8'h02);
        end
      end
      for (int i = 0; i < 16; i++) s[i] = t[i] ^ rk[r*16+i];
    end
    for (int i = 0; i < 16; i++) o[127-8*i -: 8] = s[i];
    return o;
  endfunction

  function automatic void clear_frame();
    chk_a = 0; chk_b = 0; head = {8{PAD_BYTE}}; head_cnt = 0;
  endfunction

  // Advances the frame state by one byte; returns 1 with the MAC on the last byte.
  function automatic bit mac_step(input logic [7:0] d, input logic [15:0] seq,
                                  input logic last, output mac_res_t res);
    logic [7:0] mix, nf;
    logic [127:0] ct;
    mix = d ^ chk_b;
    nf = {chk_a[6:0], mix[7]};
    if (chk_a[7]) begin
      chk_a = nf ^ PAD_BYTE; chk_b = {mix[6:0], 1'b0} ^ CHK_XOR2;
    end else begin
      chk_a = nf; chk_b = {mix[6:0], 1'b0};
    end
    if (head_cnt < 8) begin
      head[63-8*head_cnt -: 8] = d;
      head_cnt++;
    end
    res = '0;
    if (!last) return 0;
    ct = aes128({key_hi, key_lo}, {head, chk_a, chk_b, seq, {4{PAD_BYTE}}});
    res.mac = ct[127:80];
    res.chk = {chk_a, chk_b};
    clear_frame();
    return 1;
  endfunction

  task automatic cfg_write(input logic idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_KEY_HI) key_hi = val; else key_lo = val;
  endtask

  // Sends one byte; the predicted result (if any) is queued at acceptance.
  // The beat stays valid on return so that the next byte can follow directly.
  task automatic send_byte(input logic [7:0] d, input logic [15:0] seq, input logic last,
                           output mac_res_t res, output bit got);
    while (src_idle > 0 && $urandom_range(99) < src_idle) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {seq, d};
    s_axis_tlast <= last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    got = mac_step(d, seq, last, res);
    if (got) begin
      mac_q.push_back(res);
      n_frames++;
    end
    n_bytes++;
    @(negedge clk);
  endtask

  task automatic send_frame(input int len);
    mac_res_t r;
    bit g;
    for (int i = 0; i < len; i++)
      send_byte(8'($urandom_range(255)), 16'($urandom_range(65535)), i == len - 1, r, g);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (mac_q.size() != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  // Sink side: random backpressure, compare at the rising edge.
  always @(negedge clk) begin
    if (rst) m_axis_tready <= 1'b0;
    else m_axis_tready <= snk_hold ? 1'b0 : ($urandom_range(99) >= snk_idle);
  end

  always @(posedge clk) begin
    mac_res_t exp_r, got_r;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_r = {m_axis_tdata[47:0], m_axis_tdata[63:48]};
      n_beats++;
      if (mac_q.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("Unexpected output beat: %h", m_axis_tdata);
      end else begin
        exp_r = mac_q.pop_front();
        if (got_r.mac !== exp_r.mac || got_r.chk !== exp_r.chk) begin
          n_err++;
          if (n_err <= 10)
            $display("Mismatch: mac exp %h got %h, check exp %h got %h",
                     exp_r.mac, got_r.mac, exp_r.chk, got_r.chk);
        end
      end
    end
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    dir_row_t rows [$];
    dir_row_t row;
    mac_res_t r;
    bit g;
    key_hi = 0; key_lo = 0;
    clear_frame();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: one-byte frames at the extremes, short, exact-head and long frames.
    // The all-zero one-byte frame under the all-zero key has its checksum typed in.
    rows.push_back('{8'h00, 16'h0000, 1'b1, 1'b1, '{48'h0, 16'h0000}});
    rows.push_back('{8'hff, 16'hffff, 1'b1, 1'b0, '0});
    rows.push_back('{8'h80, 16'h8000, 1'b1, 1'b0, '0});
    for (int i = 0; i < 8; i++)
      rows.push_back('{8'(8'h11 * i), 16'h1234, i == 7, 1'b0, '0});
    for (int i = 0; i < 12; i++)
      rows.push_back('{8'hff, 16'h00ff, i == 11, 1'b0, '0});
    rows.push_back('{8'h7f, 16'hff00, 1'b0, 1'b0, '0});
    rows.push_back('{8'h01, 16'h0001, 1'b1, 1'b0, '0});
    foreach (rows[i]) begin
      row = rows[i];
      send_byte(row.data, row.seq, row.last, r, g);
      if (row.typed && g && r.chk !== row.res.chk) begin
        n_err++;
        if (n_err <= 10) $display("Directed checksum exp %h got %h", row.res.chk, r.chk);
      end
    end
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_KEY_HI, '1); cfg_write(CFG_KEY_LO, '1); end
        1: begin cfg_write(CFG_KEY_HI, 64'h2b7e151628aed2a6);
                 cfg_write(CFG_KEY_LO, 64'habf7158809cf4f3c); end
        default: begin cfg_write(CFG_KEY_HI, {$urandom, $urandom});
                       cfg_write(CFG_KEY_LO, {$urandom, $urandom}); end
      endcase
      src_idle = (ph == 0) ? 6 : (ph == 1) ? 45 : 0;
      snk_idle = (ph == 0) ? 45 : (ph == 1) ? 6 : 0;
      while (n_bytes < 30 + 340 * (ph + 1)) begin
        send_frame(($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12));
        if (ph == 1 && $urandom_range(15) == 0) begin
          s_axis_tvalid <= 1'b0;
          while (mac_q.size() != 0) @(negedge clk);
        end
      end
      drain();
    end

    $display("Covered %0d payload bytes in %0d frames, %0d MAC beats checked,",
             n_bytes, n_frames, n_beats);
    $display("across four key settings with stalls on each side and none.");
    if (n_err == 0 && mac_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

// ----- sim.f -----
rtl/fam_pkg.sv
rtl/fam_front.sv
rtl/fam_aes.sv
rtl/frame_auth_mac.sv
tb/tb_frame_auth_mac.sv
